/* hw/rtl/sad_pkg.sv */
// Shared types and constants of the sensor average and distance block.
package sad_pkg;

    localparam int DIST_W      = 10;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT = 1'b1;

    localparam int LOW_LIMIT_RESET  = 100;
    localparam int HIGH_LIMIT_RESET = 900;

    localparam real DIST_SCALE    = 26704.0;
    localparam real DIST_EXPONENT = -0.769;
    localparam real TENTHS_MIN    = 150.0;
    localparam real TENTHS_MAX    = 600.0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_EMIT
    } sad_state_t;

endpackage

/* hw/rtl/sad_interfaces.sv */
// Handshake channels of the sensor average and distance block.
interface sad_sample_if #(parameter int SAMPLE_BITS = 10);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sad_result_if #(parameter int SAMPLE_BITS = 10);
    import sad_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] averaged;
    logic [DIST_W-1:0]      distance_tenths;
    logic                   distance_valid;

    modport source (output valid, output averaged, output distance_tenths,
                    output distance_valid, input ready);
    modport sink   (input valid, input averaged, input distance_tenths,
                    input distance_valid, output ready);
endinterface

interface sad_cfg_if #(parameter int SAMPLE_BITS = 10);
    import sad_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [SAMPLE_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/sad_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module sad_divider #(
    parameter int DIVIDEND_W = 13,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/sensor_average_and_distance.sv */
// Moving average of range-sensor samples with conversion to distance.
//
// Each sample transfer goes into a ring of the last WINDOW samples and updates a
// running total; the total is divided by the fill count (1 to WINDOW) in a
// bit-serial divider, giving the truncated mean. The mean indexes a distance
// table built at elaboration, floor(26704 * v^-0.769) in tenths of a centimetre,
// which reads zero wherever the distance falls outside 15.0 to 60.0 cm. A mean
// of zero or outside the two limit registers gives an invalid distance of zero.
// The bit-serial divider produces one quotient bit per cycle over the
// running-total width. A new sample is taken while the previous result still
// waits in the output register. Limit writes are taken in any cycle.
module sensor_average_and_distance
    import sad_pkg::*;
#(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic  clk,
    input  logic  rst_n,
    sad_sample_if.sink   samples,
    sad_result_if.source results,
    sad_cfg_if.sink      cfg
);

    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int TOTAL_W   = $clog2(WINDOW * (2 ** SAMPLE_BITS - 1) + 1);
    localparam int ROM_DEPTH = 2 ** SAMPLE_BITS;

    typedef logic [DIST_W-1:0] dist_rom_t [ROM_DEPTH];

    function automatic dist_rom_t build_dist_rom();
        dist_rom_t rom;
        real       x;
        for (int v = 0; v < ROM_DEPTH; v++)
        begin
            rom[v] = '0;
            if (v != 0)
            begin
                x = DIST_SCALE * $pow(real'(v), DIST_EXPONENT);
                if (x >= TENTHS_MIN && x < TENTHS_MAX)
                    rom[v] = DIST_W'($rtoi(x));
            end
        end
        return rom;
    endfunction

    localparam dist_rom_t DIST_ROM = build_dist_rom();

    sad_state_t              state_reg, state_next;
    logic [SAMPLE_BITS-1:0]  window_mem [WINDOW];
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  old_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [SAMPLE_BITS-1:0]  avg_reg;
    logic [DIST_W-1:0]       rom_reg;
    logic [SAMPLE_BITS-1:0]  low_reg;
    logic [SAMPLE_BITS-1:0]  high_reg;

    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  averaged_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    dist_valid_reg;

    logic                    in_ready;
    logic                    div_start;
    logic                    load_out;
    logic                    window_full;
    logic                    in_limits;
    logic                    div_done;
    logic [TOTAL_W-1:0]      div_quotient;

    assign window_full = fill_reg == FILL_W'(WINDOW);
    assign fill_next   = window_full ? fill_reg : fill_reg + 1'b1;
    assign total_next  = total_reg
                       - (window_full ? TOTAL_W'(old_reg) : '0)
                       + TOTAL_W'(sample_reg);
    assign in_limits   = (avg_reg != '0) && (avg_reg >= low_reg) && (avg_reg <= high_reg)
                       && (rom_reg != '0);

    sad_divider #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (FILL_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (samples.valid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            low_reg       <= SAMPLE_BITS'(LOW_LIMIT_RESET);
            high_reg      <= SAMPLE_BITS'(HIGH_LIMIT_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
            begin
                total_reg <= total_next;
                fill_reg  <= fill_next;
                slot_reg  <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_LOW_LIMIT:  low_reg  <= cfg.data;
                    CFG_HIGH_LIMIT: high_reg <= cfg.data;
                    default:        ;
                endcase
            end
        end
    end

    // ring of past samples
    always_ff @(posedge clk)
    begin
        if (in_ready && samples.valid)
            old_reg <= window_mem[slot_reg];
        if (state_reg == ST_UPDATE)
            window_mem[slot_reg] <= sample_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && samples.valid)
            sample_reg <= samples.sample;
        if (state_reg == ST_DIVIDE && div_done)
            avg_reg <= div_quotient[SAMPLE_BITS-1:0];
        if (state_reg == ST_LOOKUP)
            rom_reg <= DIST_ROM[avg_reg];
        if (load_out)
        begin
            averaged_reg   <= avg_reg;
            dist_reg       <= in_limits ? rom_reg : '0;
            dist_valid_reg <= in_limits;
        end
    end

    assign samples.ready           = in_ready;
    assign cfg.ready               = 1'b1;
    assign results.valid           = out_valid_reg;
    assign results.averaged        = averaged_reg;
    assign results.distance_tenths = dist_reg;
    assign results.distance_valid  = dist_valid_reg;

endmodule

/* dv/sensor_average_and_distance_tb.sv */
// Testbench: random samples and limit writes checked against an average and distance predictor.
module sensor_average_and_distance_tb;
    import sad_pkg::*;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_BITS = 10;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] averaged;
        logic [DIST_W-1:0]      distance_tenths;
        logic                   distance_valid;
    } reading_t;

    logic clk;
    logic rst_n;

    sad_sample_if #(SAMPLE_BITS) sample_ch ();
    sad_result_if #(SAMPLE_BITS) result_ch ();
    sad_cfg_if    #(SAMPLE_BITS) cfg_ch ();

    sensor_average_and_distance #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    logic [SAMPLE_BITS-1:0] window_ring [WINDOW];
    logic [2:0]             write_pos;
    logic                   window_filled;
    logic [12:0]            window_total;
    logic [SAMPLE_BITS-1:0] low_limit;
    logic [SAMPLE_BITS-1:0] high_limit;

    int       tenths_of_mean [SAMPLE_MAX+1];
    bit       tenths_in_span [SAMPLE_MAX+1];
    reading_t pending_readings [$];
    int       mismatch_count;
    bit       no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic reading_t average_and_range(input logic [SAMPLE_BITS-1:0] value);
        reading_t r;
        int       count;
        bit       accepted;
        window_total = window_total - window_ring[write_pos] + value;
        window_ring[write_pos] = value;
        if (write_pos == 3'(WINDOW - 1))
            window_filled = 1'b1;
        write_pos = write_pos + 3'd1;
        count = window_filled ? WINDOW : int'(write_pos);
        r.averaged = SAMPLE_BITS'(int'(window_total) / count);
        accepted = r.averaged != 0 && r.averaged >= low_limit && r.averaged <= high_limit;
        r.distance_valid = accepted && tenths_in_span[r.averaged];
        r.distance_tenths = r.distance_valid ? DIST_W'(tenths_of_mean[r.averaged]) : '0;
        return r;
    endfunction

    task automatic send_sample(input int value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= SAMPLE_BITS'(value);
        do @(posedge clk); while (!sample_ch.ready);
        pending_readings.push_back(average_and_range(SAMPLE_BITS'(value)));
    endtask

    // hold the sender until every expected reading has come back
    task automatic drain_readings();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    task automatic set_limits(input int low, input int high);
        drain_readings();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_LOW_LIMIT;
        cfg_ch.data  <= SAMPLE_BITS'(low);
        do @(posedge clk); while (!cfg_ch.ready);
        low_limit = SAMPLE_BITS'(low);
        cfg_ch.index <= CFG_HIGH_LIMIT;
        cfg_ch.data  <= SAMPLE_BITS'(high);
        do @(posedge clk); while (!cfg_ch.ready);
        high_limit = SAMPLE_BITS'(high);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_run(input int value, input int length);
        repeat (length) send_sample(value);
    endtask

    task automatic test_fill_and_extremes();
        send_sample(0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(0);
        send_sample(512);
        send_sample(1);
        send_sample(LOW_LIMIT_RESET);
        send_sample(HIGH_LIMIT_RESET);
        send_run(140, WINDOW);
        send_run(846, WINDOW);
    endtask

    task automatic test_limit_settings();
        set_limits(0, SAMPLE_MAX);
        send_run(1, WINDOW);
        send_run(0, WINDOW);
        repeat (8) send_sample($urandom_range(0, SAMPLE_MAX));
        // low above high: reject every mean
        set_limits(SAMPLE_MAX, 0);
        repeat (16) send_sample($urandom_range(0, SAMPLE_MAX));
        set_limits(SAMPLE_MAX, SAMPLE_MAX);
        send_run(SAMPLE_MAX, WINDOW);
        set_limits(300, 300);
        send_run(300, WINDOW);
    endtask

    task automatic test_random_phases();
        int lo;
        int hi;
        int sent;
        int base;
        int len;
        int value;
        for (int phase = 0; phase < 10; phase++)
        begin
            lo = $urandom_range(0, 400);
            hi = $urandom_range(500, SAMPLE_MAX);
            if (phase == 3)
                set_limits(hi, lo);
            else if (phase == 7)
                set_limits(lo, lo);
            else
                set_limits(lo, hi);
            no_gaps = (phase % 4 == 2);
            sent = 0;
            while (sent < 130)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    base = $urandom_range(0, SAMPLE_MAX);
                    if ($urandom_range(0, 4) == 0)
                        base = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                    len = $urandom_range(8, 16);
                    for (int i = 0; i < len; i++)
                    begin
                        value = base + $urandom_range(0, 16) - 8;
                        if (value < 0)
                            value = 0;
                        if (value > SAMPLE_MAX)
                            value = SAMPLE_MAX;
                        send_sample(value);
                    end
                    sent += len;
                end
                else
                begin
                    send_sample($urandom_range(0, SAMPLE_MAX));
                    sent++;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin : reading_sink
        int       stall;
        reading_t want;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
            if (pending_readings.size() == 0)
            begin
                flag_mismatch("unexpected reading, averaged", result_ch.averaged, -1);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (result_ch.averaged !== want.averaged)
                    flag_mismatch("averaged", result_ch.averaged, want.averaged);
                if (result_ch.distance_tenths !== want.distance_tenths)
                    flag_mismatch("distance_tenths", result_ch.distance_tenths,
                                  want.distance_tenths);
                if (result_ch.distance_valid !== want.distance_valid)
                    flag_mismatch("distance_valid", result_ch.distance_valid,
                                  want.distance_valid);
            end
        end
    end

    initial
    begin
        real exact;
        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_LOW_LIMIT;
        cfg_ch.data      <= '0;
        mismatch_count = 0;
        no_gaps = 1'b0;
        for (int i = 0; i < WINDOW; i++)
            window_ring[i] = '0;
        write_pos     = '0;
        window_filled = 1'b0;
        window_total  = '0;
        low_limit     = SAMPLE_BITS'(LOW_LIMIT_RESET);
        high_limit    = SAMPLE_BITS'(HIGH_LIMIT_RESET);
        tenths_of_mean[0] = 0;
        tenths_in_span[0] = 1'b0;
        for (int v = 1; v <= SAMPLE_MAX; v++)
        begin
            exact = DIST_SCALE * (real'(v) ** DIST_EXPONENT);
            tenths_in_span[v] = exact >= TENTHS_MIN && exact < TENTHS_MAX;
            tenths_of_mean[v] = tenths_in_span[v] ? $rtoi(exact) : 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_extremes();
        test_limit_settings();
        test_random_phases();

        drain_readings();
        repeat (40) @(posedge clk);
        if (pending_readings.size() != 0)
            flag_mismatch("readings left over", pending_readings.size(), 0);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
